// ----- sv/leaf_rank_select_access_assert.svh -----
// Assertion macros for the leaf rank/select block.
// Included by the modules that check their own logic; expects clk and arst_n in scope.
`ifndef LEAF_RANK_SELECT_ACCESS_ASSERT_SVH
`define LEAF_RANK_SELECT_ACCESS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRSA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LRSA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/lrsa_pkg.sv -----
// Shared types and constants for the leaf rank/select block.
// Used by lrsa_mem and leaf_rank_select_access; depends on nothing.
package lrsa_pkg;

	// Default leaf depth in symbols.
	localparam int LEAF_MAX_DEF = 64;

	// Fixed field widths.
	localparam int SYM_W = 8;
	localparam int POS_W = 6;
	localparam int OCC_W = 7;
	localparam int VAL_W = 8;

	// Request operation codes.
	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_ACCESS = 2'd1,
		OP_RANK   = 2'd2,
		OP_SELECT = 2'd3
	} op_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_ACCESS = 2'd1,
		ST_SCAN   = 2'd2,
		ST_DRAIN  = 2'd3
	} state_t;

endpackage

// ----- sv/lrsa_mem.sv -----
// Leaf symbol memory: one write port and one read port with registered read data.
// Depends on lrsa_pkg for the symbol width.
module lrsa_mem #(
	parameter int DEPTH = lrsa_pkg::LEAF_MAX_DEF,
	parameter int AW    = 6
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [AW-1:0]            waddr,
	input  logic [lrsa_pkg::SYM_W-1:0] wdata,
	input  logic [AW-1:0]            raddr,
	output logic [lrsa_pkg::SYM_W-1:0] rdata
);

	logic [lrsa_pkg::SYM_W-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/leaf_rank_select_access.sv -----
// Top level of the leaf rank/select block: request decode, scan controller and result register.
// Depends on lrsa_pkg, lrsa_mem and leaf_rank_select_access_assert.svh.
//
// Channel   Direction  Handshake            Payload
// request   in         start while !busy    operation, first, symbol, position, occurrence
// result    out        done, one cycle      value, found
//
// A load gives no result and leaves the controller idle.
// Access answers an out-of-range position without a read, otherwise from the leaf memory read.
// Rank scans positions 0 through the clamped position, one symbol per cycle from the single
// read port of the leaf memory.
// Select scans until the match or the end of the leaf.
// Reset empties the leaf at once; the receiver cannot stall, so busy depends only on the
// controller state.
`include "leaf_rank_select_access_assert.svh"

module leaf_rank_select_access #(
	parameter int LEAF_MAX = lrsa_pkg::LEAF_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 operation,
	input  logic                       first,
	input  logic [lrsa_pkg::SYM_W-1:0] symbol,
	input  logic [lrsa_pkg::POS_W-1:0] position,
	input  logic [lrsa_pkg::OCC_W-1:0] occurrence,
	output logic                       done,
	output logic [lrsa_pkg::VAL_W-1:0] value,
	output logic                       found
);

	localparam int AW = (LEAF_MAX > 1) ? $clog2(LEAF_MAX) : 1;
	localparam int CW = $clog2(LEAF_MAX + 1);
	localparam int PW = (CW > lrsa_pkg::POS_W) ? CW : lrsa_pkg::POS_W;

	lrsa_pkg::state_t state_q, state_d;
	lrsa_pkg::op_t    op_in, op_q;

	logic [CW-1:0]                count_q;
	logic [lrsa_pkg::SYM_W-1:0]   sym_q;
	logic [AW-1:0]                idx_q, last_q;
	logic [lrsa_pkg::OCC_W-1:0]   left_q;
	logic [lrsa_pkg::VAL_W-1:0]   hits_q;
	logic                         rd_vld_s1, last_s1;
	logic [AW-1:0]                idx_s1;
	logic                         done_q, found_q;
	logic [lrsa_pkg::VAL_W-1:0]   value_q;

	logic                         accept, in_range, count_zero, has_room;
	logic [AW-1:0]                rank_stop, sel_last;
	logic                         match, sel_hit, finish, issue;
	logic                         mem_we;
	logic [AW-1:0]                mem_waddr, mem_raddr;
	logic [lrsa_pkg::SYM_W-1:0]   mem_rdata;
	logic                         res_set, res_found;
	logic [lrsa_pkg::VAL_W-1:0]   res_value;

	// Request decode.
	assign op_in      = lrsa_pkg::op_t'(operation);
	assign accept     = start && (state_q == lrsa_pkg::ST_IDLE);
	assign busy       = (state_q != lrsa_pkg::ST_IDLE);
	assign in_range   = PW'(position) < PW'(count_q);
	assign count_zero = (count_q == '0);
	assign has_room   = count_q < CW'(LEAF_MAX);
	assign sel_last   = AW'(count_q - CW'(1));
	assign rank_stop  = in_range ? AW'(position) : sel_last;

	// Scan compare on the symbol returned by the memory.
	assign match   = (mem_rdata == sym_q);
	assign sel_hit = rd_vld_s1 && (op_q == lrsa_pkg::OP_SELECT) && match
		&& (left_q == lrsa_pkg::OCC_W'(1));
	assign finish  = rd_vld_s1 && (last_s1 || sel_hit);
	assign issue   = (state_q == lrsa_pkg::ST_SCAN) && !sel_hit;

	// Memory port control.
	assign mem_we    = accept && (op_in == lrsa_pkg::OP_LOAD) && (first || has_room);
	assign mem_waddr = first ? '0 : AW'(count_q);
	assign mem_raddr = (state_q == lrsa_pkg::ST_SCAN) ? idx_q : AW'(position);

	lrsa_mem #(
		.DEPTH (LEAF_MAX),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (symbol),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lrsa_pkg::ST_IDLE: begin
				if (accept) begin
					unique case (op_in)
						lrsa_pkg::OP_LOAD: state_d = lrsa_pkg::ST_IDLE;
						lrsa_pkg::OP_ACCESS: begin
							if (in_range) state_d = lrsa_pkg::ST_ACCESS;
						end
						lrsa_pkg::OP_RANK: begin
							if (!count_zero) state_d = lrsa_pkg::ST_SCAN;
						end
						lrsa_pkg::OP_SELECT: begin
							if (!count_zero && (occurrence != '0)) state_d = lrsa_pkg::ST_SCAN;
						end
						default: state_d = lrsa_pkg::ST_IDLE;
					endcase
				end
			end
			lrsa_pkg::ST_ACCESS: state_d = lrsa_pkg::ST_IDLE;
			lrsa_pkg::ST_SCAN: begin
				if (sel_hit) state_d = lrsa_pkg::ST_IDLE;
				else if (idx_q == last_q) state_d = lrsa_pkg::ST_DRAIN;
			end
			lrsa_pkg::ST_DRAIN: state_d = lrsa_pkg::ST_IDLE;
			default: state_d = lrsa_pkg::ST_IDLE;
		endcase
	end

	// Result selection: immediate answers, access read, or end of a scan.
	always_comb begin
		res_set   = 1'b0;
		res_value = '0;
		res_found = 1'b0;
		if (accept && (op_in == lrsa_pkg::OP_ACCESS) && !in_range) begin
			res_set = 1'b1;
		end else if (accept && (op_in == lrsa_pkg::OP_RANK) && count_zero) begin
			res_set   = 1'b1;
			res_found = 1'b1;
		end else if (accept && (op_in == lrsa_pkg::OP_SELECT)
				&& (count_zero || (occurrence == '0))) begin
			res_set = 1'b1;
		end else if (state_q == lrsa_pkg::ST_ACCESS) begin
			res_set   = 1'b1;
			res_value = mem_rdata;
			res_found = 1'b1;
		end else if (finish) begin
			res_set = 1'b1;
			if (op_q == lrsa_pkg::OP_RANK) begin
				res_value = hits_q + lrsa_pkg::VAL_W'(match);
				res_found = 1'b1;
			end else if (sel_hit) begin
				res_value = lrsa_pkg::VAL_W'(idx_s1);
				res_found = 1'b1;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lrsa_pkg::ST_IDLE;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			done_q    <= res_set;
			if (accept && (op_in == lrsa_pkg::OP_LOAD)) begin
				if (first) count_q <= CW'(1);
				else if (has_room) count_q <= count_q + CW'(1);
			end
		end
	end

	// Scan and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= op_in;
			sym_q  <= symbol;
			left_q <= occurrence;
			hits_q <= '0;
			idx_q  <= '0;
			last_q <= (op_in == lrsa_pkg::OP_RANK) ? rank_stop : sel_last;
		end else begin
			if (issue) begin
				idx_q <= idx_q + AW'(1);
			end
			if (rd_vld_s1 && match) begin
				hits_q <= hits_q + lrsa_pkg::VAL_W'(1);
				left_q <= left_q - lrsa_pkg::OCC_W'(1);
			end
		end
		if (issue) begin
			idx_s1  <= idx_q;
			last_s1 <= (idx_q == last_q);
		end
		if (res_set) begin
			value_q <= res_value;
			found_q <= res_found;
		end
	end

	assign done  = done_q;
	assign value = value_q;
	assign found = found_q;

	// Checks on the controller.
	`LRSA_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(LEAF_MAX), "leaf count exceeds depth")
	`LRSA_ASSERT_IMP(a_read_in_scan, rd_vld_s1, (state_q == lrsa_pkg::ST_SCAN) || (state_q == lrsa_pkg::ST_DRAIN), "scan data outside a scan")
	`LRSA_ASSERT_IMP(a_drain_last, state_q == lrsa_pkg::ST_DRAIN, rd_vld_s1 && last_s1, "drain without last symbol")
	`LRSA_ASSERT_NXT(a_first_load, accept && (op_in == lrsa_pkg::OP_LOAD) && first, count_q == CW'(1), "first load did not restart the leaf")

endmodule
